// ===== hdl/m4inv_pkg.sv =====
`default_nettype none

package m4inv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int LIMB_W    = 33;
  localparam int OPW       = 2 * LIMB_W;
  localparam int PW        = 2 * LIMB_W;
  localparam int AW        = 136;
  localparam int SH2       = 2 * FRAC_BITS;
  localparam int SH3       = 3 * FRAC_BITS;
  localparam int XW        = AW + SH2 + ELEM_W;
  localparam int NELEM     = 16;
  localparam int NMIN      = 12;
  localparam int DIV_STEPS = ELEM_W;

  localparam logic [AW-1:0]     SAT_LIM = AW'(33'h0_8000_0000);
  localparam logic [ELEM_W-1:0] OUT_MAX = 32'h7fff_ffff;
  localparam logic [ELEM_W-1:0] OUT_MIN = 32'h8000_0000;
  localparam logic [3:0]        LAST_POS   = 4'd15;
  localparam logic [3:0]        LAST_MINOR = 4'd11;

  // minor k = m[p]*m[q] - m[r]*m[s]
  localparam logic [3:0] MINOR_IDX [NMIN][4] = '{
    '{4'd0, 4'd5, 4'd1, 4'd4},    '{4'd0, 4'd6, 4'd2, 4'd4},
    '{4'd0, 4'd7, 4'd3, 4'd4},    '{4'd1, 4'd6, 4'd2, 4'd5},
    '{4'd1, 4'd7, 4'd3, 4'd5},    '{4'd2, 4'd7, 4'd3, 4'd6},
    '{4'd8, 4'd13, 4'd9, 4'd12},  '{4'd8, 4'd14, 4'd10, 4'd12},
    '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
    '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
  };

  // cofactor k: three terms of (element, minor, negate)
  localparam logic [3:0] COF_TERMS [NELEM][3][3] = '{
    '{'{4'd5, 4'd11, 4'd0},  '{4'd6, 4'd10, 4'd1},  '{4'd7, 4'd9, 4'd0}},
    '{'{4'd1, 4'd11, 4'd1},  '{4'd2, 4'd10, 4'd0},  '{4'd3, 4'd9, 4'd1}},
    '{'{4'd13, 4'd5, 4'd0},  '{4'd14, 4'd4, 4'd1},  '{4'd15, 4'd3, 4'd0}},
    '{'{4'd9, 4'd5, 4'd1},   '{4'd10, 4'd4, 4'd0},  '{4'd11, 4'd3, 4'd1}},
    '{'{4'd4, 4'd11, 4'd1},  '{4'd6, 4'd8, 4'd0},   '{4'd7, 4'd7, 4'd1}},
    '{'{4'd0, 4'd11, 4'd0},  '{4'd2, 4'd8, 4'd1},   '{4'd3, 4'd7, 4'd0}},
    '{'{4'd12, 4'd5, 4'd1},  '{4'd14, 4'd2, 4'd0},  '{4'd15, 4'd1, 4'd1}},
    '{'{4'd8, 4'd5, 4'd0},   '{4'd10, 4'd2, 4'd1},  '{4'd11, 4'd1, 4'd0}},
    '{'{4'd4, 4'd10, 4'd0},  '{4'd5, 4'd8, 4'd1},   '{4'd7, 4'd6, 4'd0}},
    '{'{4'd0, 4'd10, 4'd1},  '{4'd1, 4'd8, 4'd0},   '{4'd3, 4'd6, 4'd1}},
    '{'{4'd12, 4'd4, 4'd0},  '{4'd13, 4'd2, 4'd1},  '{4'd15, 4'd0, 4'd0}},
    '{'{4'd8, 4'd4, 4'd1},   '{4'd9, 4'd2, 4'd0},   '{4'd11, 4'd0, 4'd1}},
    '{'{4'd4, 4'd9, 4'd1},   '{4'd5, 4'd7, 4'd0},   '{4'd6, 4'd6, 4'd1}},
    '{'{4'd0, 4'd9, 4'd0},   '{4'd1, 4'd7, 4'd1},   '{4'd2, 4'd6, 4'd0}},
    '{'{4'd12, 4'd3, 4'd1},  '{4'd13, 4'd1, 4'd0},  '{4'd14, 4'd0, 4'd1}},
    '{'{4'd8, 4'd3, 4'd0},   '{4'd9, 4'd1, 4'd1},   '{4'd10, 4'd0, 4'd0}}
  };

  typedef enum logic [3:0] {
    S_LOAD, S_TERM, S_DRAIN, S_STORE, S_DETWAIT, S_DETCHK,
    S_DIVINIT, S_DIV, S_RES, S_OUT
  } m4inv_state_t;

  typedef enum logic [1:0] {
    PH_MINOR, PH_DET, PH_COF
  } m4inv_phase_t;

  typedef struct packed {
    logic       ld_wr;
    logic [3:0] ld_addr;
    logic [3:0] e_addr;
    logic [3:0] m_addr;
    logic       cap_a;
    logic       cap_b;
    logic       src_mn;
    logic       mul;
    logic       limb_a;
    logic       limb_b;
    logic       neg;
    logic       acc_clr;
    logic       mn_wr;
    logic [3:0] k_addr;
    logic       det_ld;
    logic       div_start;
    logic       div_init;
    logic       div_step;
    logic       res_ld;
    logic [3:0] res_pos;
    logic       res_sing;
    logic       res_last;
  } m4inv_cmd_t;

  typedef struct packed {
    logic det_zero;
  } m4inv_sts_t;

endpackage

`default_nettype wire

// ===== hdl/m4inv_ctrl.sv =====
`default_nettype none

module m4inv_ctrl import m4inv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  m4inv_sts_t sts,
  output m4inv_cmd_t cmd
);

  m4inv_state_t state_r, state_nxt;
  m4inv_phase_t ph_r, ph_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] k_r, k_nxt;
  logic [2:0] j_r, j_nxt;
  logic [2:0] s_r, s_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;

  // term descriptor
  logic       a_mn, b_mn, t_neg;
  logic [3:0] a_idx, b_idx;
  logic [2:0] j_last;
  logic [2:0] sm;

  always_comb begin
    a_mn   = 1'b0;
    b_mn   = 1'b0;
    a_idx  = '0;
    b_idx  = '0;
    t_neg  = 1'b0;
    j_last = 3'd0;
    case (ph_r)
      PH_MINOR: begin
        a_idx  = MINOR_IDX[k_r][{j_r[0], 1'b0}];
        b_idx  = MINOR_IDX[k_r][{j_r[0], 1'b1}];
        t_neg  = j_r[0];
        j_last = 3'd1;
      end
      PH_DET: begin
        a_mn   = 1'b1;
        b_mn   = 1'b1;
        a_idx  = {1'b0, j_r};
        b_idx  = LAST_MINOR - {1'b0, j_r};
        t_neg  = (j_r == 3'd1) || (j_r == 3'd4);
        j_last = 3'd5;
      end
      PH_COF: begin
        b_mn   = 1'b1;
        a_idx  = COF_TERMS[k_r][j_r[1:0]][0];
        b_idx  = COF_TERMS[k_r][j_r[1:0]][1];
        t_neg  = COF_TERMS[k_r][j_r[1:0]][2][0];
        j_last = 3'd2;
      end
      default: begin
        j_last = 3'd0;
      end
    endcase
  end

  assign sm = s_r - 3'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ph_r    <= PH_MINOR;
      cnt_r   <= '0;
      k_r     <= '0;
      j_r     <= '0;
      s_r     <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      s_r     <= s_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.ld_wr   = 1'b1;
          cmd.ld_addr = cnt_r;
          cnt_nxt     = cnt_r + 4'd1;
          if (cnt_r == LAST_POS) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        case (s_r)
          3'd0: begin
            cmd.e_addr  = a_idx;
            cmd.m_addr  = a_idx;
            cmd.acc_clr = (j_r == 3'd0);
          end
          3'd1: begin
            cmd.e_addr = b_idx;
            cmd.m_addr = b_idx;
            cmd.cap_a  = 1'b1;
            cmd.src_mn = a_mn;
          end
          3'd2: begin
            cmd.cap_b  = 1'b1;
            cmd.src_mn = b_mn;
          end
          default: begin
            cmd.mul    = 1'b1;
            cmd.limb_a = sm[1];
            cmd.limb_b = sm[0];
            cmd.neg    = t_neg;
          end
        endcase
        if (s_r == 3'd6) begin
          s_nxt = '0;
          if (j_r == j_last) begin
            j_nxt     = '0;
            state_nxt = S_DRAIN;
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end else begin
          s_nxt = s_r + 3'd1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_STORE;
      end
      S_STORE: begin
        case (ph_r)
          PH_MINOR: begin
            cmd.mn_wr  = 1'b1;
            cmd.k_addr = k_r;
            state_nxt  = S_TERM;
            if (k_r == LAST_MINOR) begin
              ph_nxt = PH_DET;
              k_nxt  = '0;
            end else begin
              k_nxt = k_r + 4'd1;
            end
          end
          PH_DET: begin
            cmd.det_ld = 1'b1;
            state_nxt  = S_DETWAIT;
          end
          default: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVINIT;
          end
        endcase
      end
      S_DETWAIT: begin
        state_nxt = S_DETCHK;
      end
      S_DETCHK: begin
        if (sts.det_zero) begin
          cmd.res_ld   = 1'b1;
          cmd.res_sing = 1'b1;
          cmd.res_last = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          ph_nxt    = PH_COF;
          k_nxt     = '0;
          state_nxt = S_TERM;
        end
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 5'd1;
        if (dcnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        cmd.res_ld   = 1'b1;
        cmd.res_pos  = k_r;
        cmd.res_last = (k_r == LAST_POS);
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if ((ph_r != PH_COF) || (k_r == LAST_POS)) begin
            ph_nxt    = PH_MINOR;
            k_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_TERM;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/m4inv_dpath.sv =====
`default_nettype none

module m4inv_dpath import m4inv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  m4inv_cmd_t               cmd,
  output m4inv_sts_t               sts,
  input  logic signed [ELEM_W-1:0] in_element,
  output logic [3:0]               out_position,
  output logic signed [ELEM_W-1:0] out_inverse_element,
  output logic signed [ELEM_W-1:0] out_determinant,
  output logic                     out_singular,
  output logic                     out_overflow,
  output logic                     out_last
);

  logic [ELEM_W-1:0] emem [NELEM];
  logic [OPW-1:0]    mmem [NMIN];
  logic [ELEM_W-1:0] erd_r;
  logic [OPW-1:0]    mrd_r;
  logic [AW-1:0]     acc_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      emem[cmd.ld_addr] <= in_element;
    end
    erd_r <= emem[cmd.e_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mn_wr) begin
      mmem[cmd.k_addr] <= acc_r[OPW-1:0];
    end
    mrd_r <= mmem[cmd.m_addr];
  end

  // operand capture as sign and magnitude
  logic [OPW-1:0] cap_val, cap_mag;
  logic           cap_sgn;
  logic [OPW-1:0] amag_r, bmag_r;
  logic           asgn_r, bsgn_r;

  always_comb begin
    cap_val = cmd.src_mn ? mrd_r : {{(OPW-ELEM_W){erd_r[ELEM_W-1]}}, erd_r};
    cap_sgn = cap_val[OPW-1];
    cap_mag = cap_sgn ? (~cap_val + OPW'(1)) : cap_val;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      amag_r <= cap_mag;
      asgn_r <= cap_sgn;
    end
    if (cmd.cap_b) begin
      bmag_r <= cap_mag;
      bsgn_r <= cap_sgn;
    end
  end

  // limb multiplier, product registered before the accumulate
  logic [LIMB_W-1:0] la, lb;
  logic [PW-1:0]     prod, p_r;
  logic [1:0]        psh_r;
  logic              pneg_r, add_vld_r;
  logic [AW-1:0]     term;

  assign la   = cmd.limb_a ? amag_r[OPW-1:LIMB_W] : amag_r[LIMB_W-1:0];
  assign lb   = cmd.limb_b ? bmag_r[OPW-1:LIMB_W] : bmag_r[LIMB_W-1:0];
  assign prod = la * lb;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_r    <= prod;
      psh_r  <= {1'b0, cmd.limb_a} + {1'b0, cmd.limb_b};
      pneg_r <= asgn_r ^ bsgn_r ^ cmd.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_vld_r <= 1'b0;
    end else begin
      add_vld_r <= cmd.mul;
    end
  end

  always_comb begin
    case (psh_r)
      2'd0:    term = AW'(p_r);
      2'd1:    term = AW'(p_r) << LIMB_W;
      2'd2:    term = AW'(p_r) << (2 * LIMB_W);
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (add_vld_r) begin
      acc_r <= pneg_r ? (acc_r - term) : (acc_r + term);
    end
  end

  // determinant
  logic          acc_neg;
  logic [AW-1:0] acc_abs;
  logic [AW-1:0] dmag_r;
  logic          dsgn_r, dzero_r;
  logic [AW-1:0] dm;
  logic          dovf;
  logic [ELEM_W-1:0] dval, det_out_r;
  logic          det_ov_r;

  assign acc_neg = acc_r[AW-1];
  assign acc_abs = acc_neg ? (~acc_r + AW'(1)) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.det_ld) begin
      dmag_r  <= acc_abs;
      dsgn_r  <= acc_neg;
      dzero_r <= (acc_r == '0);
    end
  end

  assign sts.det_zero = dzero_r;

  always_comb begin
    dm   = dmag_r >> SH3;
    dovf = dsgn_r ? (dm > SAT_LIM) : (dm >= SAT_LIM);
    dval = dsgn_r ? (~dm[ELEM_W-1:0] + ELEM_W'(1)) : dm[ELEM_W-1:0];
  end

  always_ff @(posedge clk) begin
    det_out_r <= dovf ? (dsgn_r ? OUT_MIN : OUT_MAX) : dval;
    det_ov_r  <= dovf;
  end

  // restoring divider, quotient limited to the output width
  logic [AW-1:0]     cabs_r, rem_r;
  logic              csgn_r, big_r;
  logic [ELEM_W-1:0] lo_r, q_r;
  logic [XW-1:0]     nsh, dsh;
  logic [AW:0]       rem2;
  logic              ge;

  assign nsh  = XW'(cabs_r) << SH2;
  assign dsh  = XW'(dmag_r) << ELEM_W;
  assign rem2 = {rem_r, lo_r[ELEM_W-1]};
  assign ge   = rem2 >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      cabs_r <= acc_abs;
      csgn_r <= acc_neg;
    end
    if (cmd.div_init) begin
      big_r <= nsh >= dsh;
      rem_r <= AW'(nsh >> ELEM_W);
      lo_r  <= nsh[ELEM_W-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? AW'(rem2 - {1'b0, dmag_r}) : rem2[AW-1:0];
      lo_r  <= {lo_r[ELEM_W-2:0], 1'b0};
      q_r   <= {q_r[ELEM_W-2:0], ge};
    end
  end

  // signed, saturated result
  logic              ineg, iov;
  logic [ELEM_W-1:0] ival, inv;

  always_comb begin
    ineg = csgn_r ^ dsgn_r;
    iov  = big_r | (ineg ? (q_r > OUT_MIN) : q_r[ELEM_W-1]);
    ival = ineg ? (~q_r + ELEM_W'(1)) : q_r;
    inv  = iov ? (ineg ? OUT_MIN : OUT_MAX) : ival;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_position    <= cmd.res_pos;
      out_singular    <= cmd.res_sing;
      out_last        <= cmd.res_last;
      out_determinant <= det_out_r;
      if (cmd.res_sing) begin
        out_inverse_element <= '0;
        out_overflow        <= 1'b0;
      end else begin
        out_inverse_element <= inv;
        out_overflow        <= iov | det_ov_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matrix4_inverse.sv =====
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    element (signed Q16.16)
// out_      output     out_valid / out_stall  position, inverse_element, determinant,
//                                             singular, overflow, last
//
// one element item is taken per cycle while loading; the matrix is then
// worked through one shared 33x33 limb multiplier feeding a 136-bit
// accumulator and a restoring divider retiring one quotient bit per cycle
// no input item is taken from the 16th element until the last result leaves
// rst_n is synchronous, active low; it clears the controller, the load
// count and the pending-accumulate flag
// a stalled result holds the datapath until it is taken
`default_nettype none

module matrix4_inverse import m4inv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_element,
  // result item channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [3:0]               out_position,
  output logic signed [ELEM_W-1:0] out_inverse_element,
  output logic signed [ELEM_W-1:0] out_determinant,
  output logic                     out_singular,
  output logic                     out_overflow,
  output logic                     out_last
);

  // commands from the sequencer, status back from the datapath
  m4inv_cmd_t cmd;
  m4inv_sts_t sts;

  // sequencer: load count, minor / determinant / cofactor phases,
  // term and limb steps, divider step count and result handoff
  m4inv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: element store, minor store, limb multiplier, accumulator,
  // determinant scaling and saturation, divider, result register
  m4inv_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_element          (in_element),
    .out_position        (out_position),
    .out_inverse_element (out_inverse_element),
    .out_determinant     (out_determinant),
    .out_singular        (out_singular),
    .out_overflow        (out_overflow),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// ===== hdl/m4inv_checker.sv =====
`default_nettype none

module m4inv_checker import m4inv_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [3:0]               out_position,
  input logic signed [ELEM_W-1:0] out_inverse_element,
  input logic signed [ELEM_W-1:0] out_determinant,
  input logic                     out_singular,
  input logic                     out_overflow,
  input logic                     out_last
);

  // no element is taken while a result is pending
  a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_element)
      && $stable(out_position) && $stable(out_overflow))
    else $error("stalled result changed");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last && (out_position == 4'd0)
      && (out_inverse_element == '0) && (out_determinant == '0) && !out_overflow)
    else $error("bad singular result");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_singular |-> (out_last == (out_position == LAST_POS)))
    else $error("last flag out of place");

endmodule

bind matrix4_inverse m4inv_checker u_chk (.*);

`default_nettype wire
